### rtl/kdop_pkg.sv
// Package for the line offset accumulator: table sizes, request and result
// field types, result status codes and the controller-to-datapath interface structs.
// No dependencies.
package kdop_pkg;

    localparam int MAX_LINES = 64;
    localparam int IDX_W     = $clog2(MAX_LINES);
    localparam int CNT_W     = $clog2(MAX_LINES + 1);

    // Duplicate window on the Q28 dot product of two unit normals.
    localparam logic signed [32:0] DUP_LOW  = 33'sd268432772;
    localparam logic signed [32:0] DUP_HIGH = 33'sd268438140;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_POINT = 2'd1,
        MODE_READ  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_DUP  = 3'd1,
        ST_ZERO = 3'd2,
        ST_FULL = 3'd3,
        ST_BAD  = 3'd4
    } t_status;

    typedef struct packed {
        logic [5:0]         query_index;
        logic               first_point;
        logic signed [15:0] point_y;
        logic signed [15:0] point_x;
        logic               use_offset;
        logic signed [31:0] offset_in;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_x;
    } t_req;

    typedef struct packed {
        logic [6:0]         line_count;
        logic signed [31:0] offset_out;
        logic [5:0]         line_index;
        t_status            status;
    } t_res;

    typedef struct packed {
        logic             load;
        logic             sqrt_step;
        logic             div_init;
        logic             div_step;
        logic             norm_latch;
        logic             issue;
        logic [IDX_W-1:0] addr;
        logic             dup_rd;
        logic             dup_wr;
        logic             add_wr;
        logic             rd_q;
        logic             clear;
        logic             finish;
        t_status          res;
    } t_cmd;

    typedef struct packed {
        t_mode            mode;
        logic             zero;
        logic             found;
        logic             full;
        logic             bad_idx;
        logic             use_off;
        logic             out_busy;
        logic [CNT_W-1:0] count;
    } t_stat;

endpackage

### rtl/kdop_line_offset_accumulator_unit.sv
// Top level of the 2D line table with support offsets.
// Depends on kdop_pkg, kdop_ctrl, kdop_dp (and through it kdop_ram).
//
// Usage: one request enters on the slave stream and exactly one result leaves
// on the master stream. tuser carries the mode: add a line, fold in a point,
// read an offset, or clear the table. The table holds up to 64 unit normals in
// Q2.14 with a Q14 offset each.
// Steps from the accepting edge to the result:
//   add line:   one prepare step, 30 square root steps, 15 divide steps with
//               setup and latch, a walk over the normal table, a check and the
//               result step, plus a read and a write step for a duplicate merge;
//   point:      a prepare step, one walk over both tables, one line per cycle,
//               and the result step; read: a prepare, an address and the result
//               step; clear and zero normal: a prepare and the result step.
// One request is in flight at a time; ready rises again once the result is in
// the output register, so the next request can be taken while that result waits.
// Reset empties the table (line count 0) and drops any pending result; the
// table memories are not cleared, unwritten entries never reach a result.
// When the receiver stalls, the result holds on the output and a finished
// request waits in its last step until the output register frees.
module kdop_line_offset_accumulator_unit
    import kdop_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // norm_x[15:0], norm_y[31:16], offset_in[63:32], use_offset[64],
    // point_x[80:65], point_y[96:81], first_point[97], query_index[103:98]
    input  logic [103:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], line_index[8:3], offset_out[40:9], line_count[47:41]
    output logic [47:0]  m_axis_tdata
);

    t_cmd  cmd;
    t_stat stat;
    t_req  req;
    t_res  res;

    assign req = t_req'(s_axis_tdata);

    kdop_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    kdop_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_mode      (s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = res;

    // A result is only loaded into a free output register.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> !stat.out_busy)
        else $error("result loaded over a pending result");

    // A new line is only written into a table with room.
    a_add_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.add_wr |-> !stat.full)
        else $error("line written into a full table");

    // Clearing empties the table on the next cycle.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |=> (stat.count == '0))
        else $error("clear did not empty the table");

    // The line count never exceeds the table size.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= CNT_W'(MAX_LINES))
        else $error("line count above table size");

endmodule

### rtl/kdop_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module kdop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/kdop_ctrl.sv
// Controller state machine of the line offset accumulator.
// Depends on kdop_pkg; drives the datapath through t_cmd and watches t_stat.
module kdop_ctrl
    import kdop_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_SQRT, S_DIVINIT, S_DIV, S_NORM, S_SCAN, S_CHECK,
        S_DUPRD, S_DUPWR, S_POINT, S_RDADDR, S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_status         r_res, n_res;
    logic            walk_end;

    assign o_req_ready = (r_state == S_IDLE);
    assign walk_end    = (r_cnt == i_stat.count + CNT_W'(1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_res   = r_res;
        o_cmd   = '0;
        o_cmd.res  = r_res;
        o_cmd.addr = r_cnt[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                n_cnt = '0;
                n_res = ST_OK;
                unique case (i_stat.mode)
                    MODE_ADD: begin
                        if (i_stat.zero) begin
                            n_res   = ST_ZERO;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SQRT;
                        end
                    end
                    MODE_POINT: n_state = S_POINT;
                    MODE_READ:  n_state = S_RDADDR;
                    MODE_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_DONE;
                    end
                endcase
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(29)) begin
                    n_state = S_DIVINIT;
                end
            end
            S_DIVINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(14)) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                o_cmd.norm_latch = 1'b1;
                n_cnt   = '0;
                n_state = S_SCAN;
            end
            S_SCAN, S_POINT: begin
                o_cmd.issue = (r_cnt < i_stat.count);
                n_cnt = r_cnt + CNT_W'(1);
                if (walk_end) begin
                    n_state = (r_state == S_SCAN) ? S_CHECK : S_DONE;
                end
            end
            S_CHECK: begin
                priority if (i_stat.found) begin
                    n_res   = ST_DUP;
                    n_state = i_stat.use_off ? S_DUPRD : S_DONE;
                end else if (i_stat.full) begin
                    n_res   = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    o_cmd.add_wr = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DUPRD: begin
                o_cmd.dup_rd = 1'b1;
                n_state      = S_DUPWR;
            end
            S_DUPWR: begin
                o_cmd.dup_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_RDADDR: begin
                o_cmd.rd_q = 1'b1;
                n_res      = i_stat.bad_idx ? ST_BAD : ST_OK;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_res   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_res   <= n_res;
        end
    end

endmodule

### rtl/kdop_dp.sv
// Datapath of the line offset accumulator: request registers, square root and
// divider lanes, the table walk pipeline, the line tables and the result register.
// Depends on kdop_pkg and kdop_ram.
module kdop_dp
    import kdop_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    input  logic [1:0] i_mode,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_res_valid,
    input  logic  i_res_ready,
    output t_res  o_res
);

    // Request registers.
    t_mode              r_mode;
    logic signed [15:0] r_ax, r_by, r_px, r_py;
    logic signed [31:0] r_c;
    logic               r_use, r_first;
    logic [5:0]         r_q;

    // Square root of (A*A + B*B) << 28, one result bit per step.
    logic [59:0]        r_sv;
    logic [33:0]        r_rem;
    logic [29:0]        r_root;
    logic signed [31:0] sq_x, sq_y;
    logic signed [31:0] in_sq_x, in_sq_y;
    logic [32:0]        sum_sq;
    logic [33:0]        rem_sh, trial;

    // Two divider lanes, x and y.
    logic [31:0]        r_drem [2];
    logic [14:0]        r_nsh  [2];
    logic [14:0]        r_qt   [2];
    logic [15:0]        mag    [2];
    logic               neg    [2];
    logic signed [15:0] r_nx, r_ny;

    // Walk pipeline.
    logic               r_a_vld, r_b_vld;
    logic [IDX_W-1:0]   r_a_idx, r_b_idx;
    logic signed [31:0] r_b_p1, r_b_p2, r_b_off;
    logic signed [32:0] dot;
    logic signed [33:0] neg_dot;
    logic signed [31:0] pt_val;
    logic               match, pt_we;
    logic signed [15:0] op_x, op_y;

    logic               r_found;
    logic [IDX_W-1:0]   r_fidx, r_addidx;
    logic [CNT_W-1:0]   r_count;

    // Table ports.
    logic [31:0]        norm_rd, off_rd, off_wdata;
    logic [IDX_W-1:0]   off_waddr, off_raddr;
    logic               off_we, off_re;

    logic               r_ovld;
    t_res               r_res;

    assign sq_x    = r_ax * r_ax;
    assign sq_y    = r_by * r_by;
    assign in_sq_x = i_req.norm_x * i_req.norm_x;
    assign in_sq_y = i_req.norm_y * i_req.norm_y;
    assign sum_sq  = {1'b0, in_sq_x} + {1'b0, in_sq_y};
    assign rem_sh  = {r_rem[31:0], r_sv[59:58]};
    assign trial   = {2'b00, r_root, 2'b01};

    assign mag[0] = r_ax[15] ? 16'(-r_ax) : 16'(r_ax);
    assign mag[1] = r_by[15] ? 16'(-r_by) : 16'(r_by);
    assign neg[0] = r_ax[15];
    assign neg[1] = r_by[15];

    always_ff @(posedge i_clk) begin
        logic [43:0] num;
        logic [31:0] t;
        logic [14:0] qc;
        logic [15:0] qs [2];
        if (i_cmd.load) begin
            r_mode  <= t_mode'(i_mode);
            r_ax    <= i_req.norm_x;
            r_by    <= i_req.norm_y;
            r_c     <= i_req.offset_in;
            r_use   <= i_req.use_offset;
            r_px    <= i_req.point_x;
            r_py    <= i_req.point_y;
            r_first <= i_req.first_point;
            r_q     <= i_req.query_index;
            r_sv    <= {sum_sq[31:0], 28'd0};
            r_rem   <= '0;
            r_root  <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_sv <= {r_sv[57:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[28:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[28:0], 1'b0};
            end
        end
        for (int k = 0; k < 2; k++) begin
            num = {mag[k], 28'd0} + 44'(r_root[29:1]);
            t   = {r_drem[k][30:0], r_nsh[k][14]};
            qc  = (r_qt[k] > 15'd16384) ? 15'd16384 : r_qt[k];
            qs[k] = neg[k] ? 16'(-{1'b0, qc}) : {1'b0, qc};
            if (i_cmd.div_init) begin
                r_drem[k] <= {3'b000, num[43:15]};
                r_nsh[k]  <= num[14:0];
                r_qt[k]   <= '0;
            end
            if (i_cmd.div_step) begin
                r_nsh[k] <= {r_nsh[k][13:0], 1'b0};
                if (t >= {2'b00, r_root}) begin
                    r_drem[k] <= t - {2'b00, r_root};
                    r_qt[k]   <= {r_qt[k][13:0], 1'b1};
                end else begin
                    r_drem[k] <= t;
                    r_qt[k]   <= {r_qt[k][13:0], 1'b0};
                end
            end
        end
        if (i_cmd.norm_latch) begin
            r_nx <= qs[0];
            r_ny <= qs[1];
        end
    end

    // Multiplier operands: the new normal while scanning for duplicates, the point otherwise.
    assign op_x = (r_mode == MODE_ADD) ? r_nx : r_px;
    assign op_y = (r_mode == MODE_ADD) ? r_ny : r_py;

    assign dot     = 33'(r_b_p1) + 33'(r_b_p2);
    assign neg_dot = -34'(dot);
    assign match   = (dot >= DUP_LOW) && (dot <= DUP_HIGH);

    always_comb begin
        priority if (neg_dot > 34'sd2147483647) begin
            pt_val = 32'sh7FFFFFFF;
        end else if (neg_dot < -34'sd2147483648) begin
            pt_val = 32'sh80000000;
        end else begin
            pt_val = neg_dot[31:0];
        end
    end

    assign pt_we = r_b_vld && (r_mode == MODE_POINT) && (r_first || (pt_val < r_b_off));

    always_ff @(posedge i_clk) begin
        r_a_idx <= i_cmd.addr;
        r_b_idx <= r_a_idx;
        r_b_p1  <= signed'(norm_rd[15:0]) * op_x;
        r_b_p2  <= signed'(norm_rd[31:16]) * op_y;
        r_b_off <= off_rd;
        if (i_cmd.load) begin
            r_found <= 1'b0;
        end else if (r_b_vld && (r_mode == MODE_ADD) && match && !r_found) begin
            r_found <= 1'b1;
            r_fidx  <= r_b_idx;
        end
        if (i_cmd.add_wr) begin
            r_addidx <= r_count[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_count <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.issue;
            r_b_vld <= r_a_vld;
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.add_wr) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.finish) begin
                r_ovld <= 1'b1;
            end else if (i_res_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Offset table write port: walk update, duplicate merge or new line.
    always_comb begin
        off_we    = 1'b0;
        off_waddr = r_b_idx;
        off_wdata = pt_val;
        priority if (pt_we) begin
            off_we = 1'b1;
        end else if (i_cmd.dup_wr) begin
            off_we    = r_use && (r_c > signed'(off_rd));
            off_waddr = r_fidx;
            off_wdata = r_c;
        end else if (i_cmd.add_wr) begin
            off_we    = 1'b1;
            off_waddr = r_count[IDX_W-1:0];
            off_wdata = r_use ? r_c : 32'sd0;
        end else begin
            off_we = 1'b0;
        end
    end

    assign off_re    = i_cmd.issue || i_cmd.dup_rd || i_cmd.rd_q;
    assign off_raddr = i_cmd.dup_rd ? r_fidx : (i_cmd.rd_q ? r_q : i_cmd.addr);

    kdop_ram #(.WIDTH(32), .DEPTH(MAX_LINES)) u_norm_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_wr),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({r_ny, r_nx}),
        .i_re    (i_cmd.issue),
        .i_raddr (i_cmd.addr),
        .o_rdata (norm_rd)
    );

    kdop_ram #(.WIDTH(32), .DEPTH(MAX_LINES)) u_off_ram (
        .i_clk   (i_clk),
        .i_we    (off_we),
        .i_waddr (off_waddr),
        .i_wdata (off_wdata),
        .i_re    (off_re),
        .i_raddr (off_raddr),
        .o_rdata (off_rd)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res.status     <= i_cmd.res;
            r_res.line_count <= r_count;
            r_res.offset_out <= ((i_cmd.res == ST_OK) && (r_mode == MODE_READ)) ? off_rd : '0;
            unique case (i_cmd.res)
                ST_OK: begin
                    if (r_mode == MODE_ADD) begin
                        r_res.line_index <= r_addidx;
                    end else if (r_mode == MODE_READ) begin
                        r_res.line_index <= r_q;
                    end else begin
                        r_res.line_index <= '0;
                    end
                end
                ST_DUP:  r_res.line_index <= r_fidx;
                ST_BAD:  r_res.line_index <= r_q;
                default: r_res.line_index <= '0;
            endcase
        end
    end

    assign o_res_valid = r_ovld;
    assign o_res       = r_res;

    assign o_stat.mode     = r_mode;
    assign o_stat.zero     = (sq_x == 32'sd0) && (sq_y == 32'sd0);
    assign o_stat.found    = r_found;
    assign o_stat.full     = (r_count >= CNT_W'(MAX_LINES));
    assign o_stat.bad_idx  = ({1'b0, r_q} >= r_count);
    assign o_stat.use_off  = r_use;
    assign o_stat.out_busy = r_ovld && !i_res_ready;
    assign o_stat.count    = r_count;

endmodule
